/* design/aae_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package aae_pkg;

   // field widths of the payload and configuration port
   localparam int SYMBOL_W  = 9;
   localparam int FOLLOW_W  = 29;
   localparam int FREQ_W    = 17;
   localparam int INC_W     = 8;
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INCREMENT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LIMIT  = 2'd2;

   // register reset values
   localparam logic [SYMBOL_W-1:0] SYMBOL_COUNT_RST = 9'd256;
   localparam logic [INC_W-1:0]    INCREMENT_RST    = 8'd0;
   localparam logic [LIMIT_W-1:0]  TOTAL_LIMIT_RST  = 16'd256;

   // follow bit limits
   localparam logic [FOLLOW_W-1:0] PENDING_LIMIT = 29'd500000000;
   localparam logic [FOLLOW_W-1:0] PENDING_MAX   = '1;

   // result buffer
   localparam int RES_AW    = 6;
   localparam int RES_DEPTH = 64;
   localparam logic [RES_AW-1:0] RES_CAP = 6'd50;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                last_symbol;
   } req_type;

   typedef struct packed {
      logic                code_bit;
      logic [FOLLOW_W-1:0] follow_count;
      logic                run_end;
      logic                overflow;
   } rsp_type;

endpackage
`default_nettype wire

/* design/adaptive_arith_encoder_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Adaptive arithmetic encoder: one symbol per req beat, a burst of rsp beats
// (one per code bit, up to RES_CAP, each with its count of inverted follow bits) per item.
// The frequency table lives in a single-port-write, registered-read memory
// and is walked once per item to form the cumulative count; the item then
// passes through the bit-serial divide, the multiplies, the renormalise
// steps, the count update, a halving of every count when the total passes the
// limit, a flush of low after a last symbol, and the drain of the result beats.
// After reset, after a last-symbol item and after a write to symbol_count or
// increment the table is reloaded, and no item is taken during the reload.
module adaptive_arith_encoder_core #(
   parameter int TABLE_DEPTH = 256,
   parameter int CODE_BITS   = 26
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire aae_pkg::req_type         req_payload,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output aae_pkg::rsp_type              rsp_payload,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [aae_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [aae_pkg::CSR_DAT_W-1:0]  csr_data
);
   import aae_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TOT_W  = $clog2(TABLE_DEPTH * 255 + 65536);
   localparam int LOW_W  = CODE_BITS + 1;
   localparam int BIT_W  = $clog2(CODE_BITS);
   localparam int PROD_W = CODE_BITS + TOT_W;

   localparam logic [LOW_W-1:0]     HALF_SPAN   = LOW_W'(1) << (CODE_BITS - 1);
   localparam logic [LOW_W-1:0]     QTR_SPAN    = LOW_W'(1) << (CODE_BITS - 2);
   localparam logic [CODE_BITS-1:0] RANGE_RST   = CODE_BITS'(1) << (CODE_BITS - 1);
   localparam logic [CODE_BITS-1:0] RANGE_QTR   = CODE_BITS'(1) << (CODE_BITS - 2);
   localparam logic [IDX_W-1:0]     LAST_ENTRY  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [BIT_W-1:0]     TOP_BIT     = BIT_W'(CODE_BITS - 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_SUM    = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_MUL1   = 4'd3;
   localparam logic [3:0] ST_MUL2   = 4'd4;
   localparam logic [3:0] ST_APPLY  = 4'd5;
   localparam logic [3:0] ST_RENORM = 4'd6;
   localparam logic [3:0] ST_UPD    = 4'd7;
   localparam logic [3:0] ST_HALVE  = 4'd8;
   localparam logic [3:0] ST_FLUSH  = 4'd9;
   localparam logic [3:0] ST_DRREAD = 4'd10;
   localparam logic [3:0] ST_DRLOAD = 4'd11;
   localparam logic [3:0] ST_DRWAIT = 4'd12;
   localparam logic [3:0] ST_INIT   = 4'd13;

   // control registers
   logic [3:0]          state_ff, state_in;
   logic                last_ff, last_in;
   logic [IDX_W-1:0]    scan_ff, scan_in;
   logic                dvld_ff, dvld_in;
   logic [IDX_W-1:0]    didx_ff, didx_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [LOW_W-1:0]    low_ff, low_in;
   logic [CODE_BITS-1:0] range_ff, range_in;
   logic [FOLLOW_W-1:0] pend_ff, pend_in;
   logic                ovf_ff, ovf_in;
   logic [TOT_W-1:0]    total_ff, total_in;
   logic [RES_AW-1:0]   cnt_ff, cnt_in;
   logic [RES_AW-1:0]   rdp_ff, rdp_in;
   logic                rspv_ff, rspv_in;
   logic [IDX_W-1:0]    init_ff, init_in;
   logic [SYMBOL_W-1:0] symcnt_ff, symcnt_in;
   logic [INC_W-1:0]    inc_ff, inc_in;
   logic [LIMIT_W-1:0]  lim_ff, lim_in;

   // payload registers
   logic [IDX_W-1:0]    sym_ff, sym_in;
   logic [TOT_W-1:0]    cum_ff, cum_in;
   logic [FREQ_W-1:0]   f_ff, f_in;
   logic [TOT_W:0]      rem_ff, rem_in;
   logic [CODE_BITS-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0]   lowadd_ff, lowadd_in;
   logic [PROD_W-1:0]   fr_ff, fr_in;
   rsp_type             rsp_ff, rsp_in;

   // memories
   logic [FREQ_W-1:0]   freq_mem [TABLE_DEPTH];
   logic [FREQ_W-1:0]   mem_rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa, mem_ra;
   logic [FREQ_W-1:0]   mem_wd;
   logic [FOLLOW_W:0]   res_mem [RES_DEPTH];
   logic [FOLLOW_W:0]   buf_rd_ff;
   logic                buf_we;
   logic [RES_AW-1:0]   buf_wa, buf_ra;
   logic [FOLLOW_W:0]   buf_wd;

   // derived values
   logic [31:0]         sc_wide, sym_wide, s0_wide;
   logic [CNT_W-1:0]    n_act;
   logic [IDX_W-1:0]    n_last;
   logic [FREQ_W-1:0]   init_cnt;
   logic [TOT_W-1:0]    tot_eff;
   logic [CODE_BITS-1:0] q_eff;
   logic [TOT_W:0]      rem_shift;
   logic [TOT_W:0]      tot_ext;
   logic [PROD_W-1:0]   range_p, nr_raw, nr_fix;
   logic                in_tail;
   logic [LOW_W:0]      low_top;
   logic [TOT_W-1:0]    tot_new;
   logic [FREQ_W:0]     halved_w;
   logic [FOLLOW_W-1:0] pend_inc;

   // clamp the alphabet size and the incoming symbol
   assign sc_wide  = 32'(symcnt_ff);
   assign n_act    = (sc_wide == 32'd0) ? CNT_W'(1) :
                     (sc_wide > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(sc_wide);
   assign n_last   = IDX_W'(n_act - CNT_W'(1));
   assign sym_wide = 32'(req_payload.symbol);
   assign s0_wide  = (sym_wide == 32'd0) ? 32'd0 :
                     (sym_wide > 32'(n_act)) ? 32'(n_last) : sym_wide - 32'd1;
   assign init_cnt = (inc_ff == '0) ? FREQ_W'(1) : FREQ_W'(inc_ff);

   // division operands
   assign tot_eff   = (total_ff == '0) ? TOT_W'(1) : total_ff;
   assign tot_ext   = {1'b0, tot_eff};
   assign rem_shift = {rem_ff[TOT_W-1:0], range_ff[bit_ff]};
   assign q_eff     = (quo_ff == '0) ? CODE_BITS'(1) : quo_ff;

   // new range of the coded interval
   assign range_p = PROD_W'(range_ff);
   assign in_tail = ({1'b0, cum_ff} + (TOT_W + 1)'(f_ff)) >= tot_ext;
   assign nr_raw  = !in_tail ? fr_ff :
                    (range_p > lowadd_ff) ? range_p - lowadd_ff : PROD_W'(1);
   assign nr_fix  = (nr_raw == '0) ? PROD_W'(1) :
                    (nr_raw > range_p) ? range_p : nr_raw;

   assign low_top  = {1'b0, low_ff} + (LOW_W + 1)'(range_ff);
   assign tot_new  = total_ff + TOT_W'(inc_ff);
   assign halved_w = ({1'b0, mem_rd_ff} + (FREQ_W + 1)'(1)) >> 1;
   assign pend_inc = (pend_ff == PENDING_MAX) ? pend_ff : pend_ff + FOLLOW_W'(1);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      scan_in   = scan_ff;
      dvld_in   = 1'b0;
      didx_in   = didx_ff;
      bit_in    = bit_ff;
      low_in    = low_ff;
      range_in  = range_ff;
      pend_in   = pend_ff;
      ovf_in    = ovf_ff;
      total_in  = total_ff;
      cnt_in    = cnt_ff;
      rdp_in    = rdp_ff;
      rspv_in   = rspv_ff;
      init_in   = init_ff;
      symcnt_in = symcnt_ff;
      inc_in    = inc_ff;
      lim_in    = lim_ff;
      sym_in    = sym_ff;
      cum_in    = cum_ff;
      f_in      = f_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      lowadd_in = lowadd_ff;
      fr_in     = fr_ff;
      rsp_in    = rsp_ff;
      mem_we    = 1'b0;
      mem_wa    = sym_ff;
      mem_wd    = f_ff;
      mem_ra    = scan_ff;
      buf_we    = 1'b0;
      buf_wa    = cnt_ff;
      buf_wd    = {1'b0, pend_ff};
      buf_ra    = rdp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // take a symbol beat
            if (req_valid) begin
               sym_in   = IDX_W'(s0_wide);
               last_in  = req_payload.last_symbol;
               scan_in  = '0;
               cum_in   = '0;
               cnt_in   = '0;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // walk the table up to the symbol, summing the counts below it
            mem_ra  = scan_ff;
            dvld_in = 1'b1;
            didx_in = scan_ff;
            if (scan_ff != sym_ff) begin
               scan_in = scan_ff + IDX_W'(1);
            end
            if (dvld_ff) begin
               if (didx_ff == sym_ff) begin
                  f_in     = mem_rd_ff;
                  dvld_in  = 1'b0;
                  rem_in   = '0;
                  quo_in   = '0;
                  bit_in   = TOP_BIT;
                  state_in = ST_DIV;
               end else begin
                  cum_in = cum_ff + TOT_W'(mem_rd_ff);
               end
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle
            if (rem_shift >= tot_ext) begin
               rem_in = rem_shift - tot_ext;
               quo_in = {quo_ff[CODE_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[CODE_BITS-2:0], 1'b0};
            end
            if (bit_ff == '0) begin
               state_in = ST_MUL1;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_MUL1: begin
            lowadd_in = PROD_W'(q_eff) * PROD_W'(cum_ff);
            state_in  = ST_MUL2;
         end
         ST_MUL2: begin
            fr_in    = PROD_W'(q_eff) * PROD_W'(f_ff);
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            low_in   = low_ff + lowadd_ff[LOW_W-1:0];
            range_in = CODE_BITS'(nr_fix);
            state_in = ST_RENORM;
         end
         ST_RENORM: begin
            // one renormalise step per cycle
            if (range_ff > RANGE_QTR) begin
               state_in = ST_UPD;
            end else begin
               range_in = range_ff << 1;
               priority if (low_top <= (LOW_W + 1)'(HALF_SPAN)) begin
                  buf_we  = (cnt_ff < RES_CAP);
                  buf_wd  = {1'b0, pend_ff};
                  cnt_in  = (cnt_ff < RES_CAP) ? cnt_ff + RES_AW'(1) : cnt_ff;
                  pend_in = '0;
                  low_in  = low_ff << 1;
               end else if (low_ff >= HALF_SPAN) begin
                  buf_we  = (cnt_ff < RES_CAP);
                  buf_wd  = {1'b1, pend_ff};
                  cnt_in  = (cnt_ff < RES_CAP) ? cnt_ff + RES_AW'(1) : cnt_ff;
                  pend_in = '0;
                  low_in  = (low_ff - HALF_SPAN) << 1;
               end else begin
                  pend_in = pend_inc;
                  low_in  = (low_ff - QTR_SPAN) << 1;
               end
            end
         end
         ST_UPD: begin
            // raise the symbol's count and the total
            ovf_in   = ovf_ff | (pend_ff > PENDING_LIMIT);
            mem_we   = 1'b1;
            mem_wa   = sym_ff;
            mem_wd   = f_ff + FREQ_W'(inc_ff);
            total_in = tot_new;
            if (tot_new > TOT_W'(lim_ff)) begin
               total_in = '0;
               scan_in  = '0;
               state_in = ST_HALVE;
            end else if (last_ff) begin
               bit_in   = TOP_BIT;
               state_in = ST_FLUSH;
            end else begin
               rdp_in   = '0;
               state_in = (cnt_ff == '0) ? ST_IDLE : ST_DRREAD;
            end
         end
         ST_HALVE: begin
            // halve every count, rounding up, and rebuild the total
            mem_ra  = scan_ff;
            dvld_in = 1'b1;
            didx_in = scan_ff;
            if (scan_ff != n_last) begin
               scan_in = scan_ff + IDX_W'(1);
            end
            if (dvld_ff) begin
               mem_we   = 1'b1;
               mem_wa   = didx_ff;
               mem_wd   = FREQ_W'(halved_w);
               total_in = total_ff + TOT_W'(halved_w);
               if (didx_ff == n_last) begin
                  dvld_in = 1'b0;
                  if (last_ff) begin
                     bit_in   = TOP_BIT;
                     state_in = ST_FLUSH;
                  end else begin
                     rdp_in   = '0;
                     state_in = (cnt_ff == '0) ? ST_IDLE : ST_DRREAD;
                  end
               end
            end
         end
         ST_FLUSH: begin
            // shift out the code bits of low, top first
            buf_we  = (cnt_ff < RES_CAP);
            buf_wd  = {low_ff[bit_ff], pend_ff};
            cnt_in  = (cnt_ff < RES_CAP) ? cnt_ff + RES_AW'(1) : cnt_ff;
            pend_in = '0;
            if (bit_ff == '0) begin
               low_in   = '0;
               range_in = RANGE_RST;
               rdp_in   = '0;
               state_in = ST_DRREAD;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         ST_DRREAD: begin
            buf_ra   = rdp_ff;
            state_in = ST_DRLOAD;
         end
         ST_DRLOAD: begin
            rsp_in.code_bit     = buf_rd_ff[FOLLOW_W];
            rsp_in.follow_count = buf_rd_ff[FOLLOW_W-1:0];
            rsp_in.run_end      = (RES_AW'(rdp_ff + RES_AW'(1)) == cnt_ff);
            rsp_in.overflow     = ovf_ff;
            rspv_in             = 1'b1;
            state_in            = ST_DRWAIT;
         end
         ST_DRWAIT: begin
            // hold the beat until taken
            if (!rsp_stall) begin
               rspv_in = 1'b0;
               if (RES_AW'(rdp_ff + RES_AW'(1)) == cnt_ff) begin
                  cnt_in   = '0;
                  init_in  = '0;
                  state_in = last_ff ? ST_INIT : ST_IDLE;
               end else begin
                  rdp_in   = rdp_ff + RES_AW'(1);
                  state_in = ST_DRREAD;
               end
            end
         end
         ST_INIT: begin
            // reload the table, one entry per cycle
            mem_we = 1'b1;
            mem_wa = init_ff;
            mem_wd = (32'(init_ff) < 32'(n_act)) ? init_cnt : '0;
            if (init_ff == LAST_ENTRY) begin
               total_in = TOT_W'(32'(n_act) * 32'(init_cnt));
               state_in = ST_IDLE;
            end else begin
               init_in = init_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration beats; a table register restarts the reload
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SYMBOL_COUNT: begin
               symcnt_in = csr_data[SYMBOL_W-1:0];
               init_in   = '0;
               state_in  = ST_INIT;
            end
            CSR_INCREMENT: begin
               inc_in   = csr_data[INC_W-1:0];
               init_in  = '0;
               state_in = ST_INIT;
            end
            CSR_TOTAL_LIMIT: begin
               lim_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         last_ff   <= 1'b0;
         scan_ff   <= '0;
         dvld_ff   <= 1'b0;
         didx_ff   <= '0;
         bit_ff    <= '0;
         low_ff    <= '0;
         range_ff  <= RANGE_RST;
         pend_ff   <= '0;
         ovf_ff    <= 1'b0;
         total_ff  <= '0;
         cnt_ff    <= '0;
         rdp_ff    <= '0;
         rspv_ff   <= 1'b0;
         init_ff   <= '0;
         symcnt_ff <= SYMBOL_COUNT_RST;
         inc_ff    <= INCREMENT_RST;
         lim_ff    <= TOTAL_LIMIT_RST;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         scan_ff   <= scan_in;
         dvld_ff   <= dvld_in;
         didx_ff   <= didx_in;
         bit_ff    <= bit_in;
         low_ff    <= low_in;
         range_ff  <= range_in;
         pend_ff   <= pend_in;
         ovf_ff    <= ovf_in;
         total_ff  <= total_in;
         cnt_ff    <= cnt_in;
         rdp_ff    <= rdp_in;
         rspv_ff   <= rspv_in;
         init_ff   <= init_in;
         symcnt_ff <= symcnt_in;
         inc_ff    <= inc_in;
         lim_ff    <= lim_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      cum_ff    <= cum_in;
      f_ff      <= f_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      lowadd_ff <= lowadd_in;
      fr_ff     <= fr_in;
      rsp_ff    <= rsp_in;
   end

   // frequency table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         freq_mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= freq_mem[mem_ra];
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         res_mem[buf_wa] <= buf_wd;
      end
      buf_rd_ff <= res_mem[buf_ra];
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rspv_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   a_rsp_in_drain: assert property (@(posedge clock) disable iff (reset)
      rspv_ff |-> (state_ff == ST_DRWAIT))
      else $error("result beat shown outside the drain");

   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CAP)
      else $error("result count past the cap");

   a_range_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RENORM) |-> (range_ff != '0))
      else $error("coder range collapsed to zero");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> !$fell(ovf_ff))
      else $error("overflow flag cleared without reset");

endmodule
`default_nettype wire
